>>> rtl/bsct_pkg.sv
package bsct_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_ZERO_CROSS = 2'd0,
		CMD_COMMUTATE  = 2'd1,
		CMD_TICK       = 2'd2,
		CMD_START      = 2'd3
	} cmd_t;

	// result action codes
	typedef enum logic [1:0] {
		ACT_IGNORED    = 2'd0,
		ACT_SCHEDULED  = 2'd1,
		ACT_STUCK      = 2'd2,
		ACT_COMMUTATED = 2'd3
	} action_t;

	// config register indexes
	localparam logic CFG_ADVANCE   = 1'b0;
	localparam logic CFG_DIRECTION = 1'b1;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [15:0] PLAUSIBLE_MIN  = 16'd125;
	localparam logic [11:0] LOW_DUTY       = 12'd600;
	localparam logic [13:0] EARLY_CROSSES  = 14'd500;
	localparam logic [7:0]  STUCK_LIMIT    = 8'd100;
	localparam logic [7:0]  STUCK_MAX      = 8'd255;
	localparam logic [13:0] CROSS_MAX      = 14'd10000;
	localparam logic [13:0] DESYNC_CLEAR   = 14'd10;
	localparam logic [15:0] START_INTERVAL = 16'd10000;
	localparam logic [15:0] RESET_INTERVAL = 16'd12500;
	localparam int          HIST_BITS      = 24;
	localparam int          HIST_DEPTH     = 6;
	localparam logic [2:0]  STEP_FIRST     = 3'd1;
	localparam logic [2:0]  STEP_LAST      = 3'd6;
	// ceil(2^19 / 3): exact floor(x / 3) for x below 2^19 after >> 19
	localparam logic [17:0] RECIP_THREE    = 18'd174763;

	typedef struct packed {
		logic [1:0] advance_steps;
		logic       direction_forward;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		cmd_t        command;
		logic [15:0] elapsed_time;
		logic        low_early;   // elapsed and duty both under the early limits
		logic        has_one;     // a checked comparator sample is 1
		logic        has_zero;    // a checked comparator sample is 0
		logic        quick_accel;
		logic        brake_hold;
	} queue_word_t;

endpackage

>>> rtl/bsct_front.sv
module bsct_front (
	input  logic                 in_valid,
	input  logic [1:0]           command,
	input  logic [15:0]          elapsed_time,
	input  logic [23:0]          comparator_history,
	input  logic [4:0]           filter_samples,
	input  logic [11:0]          duty_level,
	input  logic                 quick_accel,
	input  logic                 brake_hold,
	input  logic                 queue_full,
	output logic                 in_stall,
	output logic                 push,
	output bsct_pkg::queue_word_t push_word
);
	import bsct_pkg::*;

	logic [4:0]  n_checked;
	logic [24:0] mask_wide;
	logic [23:0] mask;

	always_comb begin
		n_checked = (filter_samples > 5'(HIST_BITS)) ? 5'(HIST_BITS) : filter_samples;
		mask_wide = (25'd1 << n_checked) - 25'd1;
		mask      = mask_wide[23:0];
	end

	assign in_stall = queue_full;
	assign push     = in_valid & ~queue_full;

	always_comb begin
		push_word.command      = cmd_t'(command);
		push_word.elapsed_time = elapsed_time;
		push_word.low_early    = (elapsed_time < PLAUSIBLE_MIN) && (duty_level < LOW_DUTY);
		push_word.has_one      = |(comparator_history & mask);
		push_word.has_zero     = |(~comparator_history & mask);
		push_word.quick_accel  = quick_accel;
		push_word.brake_hold   = brake_hold;
	end

endmodule

>>> rtl/bsct_queue.sv
module bsct_queue #(
	parameter int DEPTH = bsct_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bsct_pkg::queue_word_t push_word,
	input  logic                  pop,
	output logic                  pop_valid,
	output bsct_pkg::queue_word_t pop_word,
	output logic                  full
);
	import bsct_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	queue_word_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign pop_valid = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign pop_word  = mem_q[rd_ptr_q];
	assign do_pop    = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/bsct_back.sv
module bsct_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsct_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	input  bsct_pkg::queue_word_t q_word,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            action,
	output logic [15:0]           wait_time,
	output logic [2:0]            phase_step,
	output logic                  edge_rising,
	output logic                  drive_update,
	output logic [17:0]           period_sum,
	output logic                  desync_mark,
	output logic [13:0]           cross_count
);
	import bsct_pkg::*;

	// motor state
	logic [15:0] hist_q [HIST_DEPTH];
	logic [18:0] sum_q;          // full sum of the six intervals
	logic [15:0] smoothed_q;
	logic [2:0]  step_q;
	logic        rising_q;
	logic [13:0] crossings_q;
	logic [15:0] avg_q;
	logic [7:0]  stuck_q;
	logic        running_q;
	logic        wrap_q;

	// output register
	logic        out_valid_q;
	action_t     action_q;
	logic [15:0] wait_q;
	logic        drive_q;

	// next state
	logic [18:0] sum_n;
	logic [15:0] smoothed_n;
	logic [2:0]  step_n;
	logic        rising_n;
	logic [13:0] crossings_n;
	logic [15:0] avg_n;
	logic [7:0]  stuck_n;
	logic        running_n;
	logic        wrap_n;
	logic        hist_we;
	action_t     action_n;
	logic [15:0] wait_n;
	logic        drive_n;

	// commutation candidate
	logic [2:0]  com_idx;
	logic [18:0] com_sum;
	logic [2:0]  com_step;
	logic        com_rising;
	logic        com_wrap;

	// zero-cross datapath
	logic        plaus_on;
	logic        early;
	logic        too_soon;
	logic [7:0]  stuck_inc;
	logic        filter_ok;
	logic [17:0] smooth_acc;
	logic [15:0] smooth_new;
	logic [12:0] eighth;
	logic [14:0] adv;
	logic [14:0] half_diff;

	// slow tick divide by three
	logic [35:0] div_prod;
	logic [13:0] cross_inc;

	assign q_pop = q_valid & (~out_valid_q | ~out_stall);

	always_comb begin
		com_idx = step_q - 3'd1;
		com_sum = sum_q - {3'd0, hist_q[com_idx]} + {3'd0, smoothed_q};
		com_wrap = 1'b0;
		if (cfg.direction_forward) begin
			if (step_q >= STEP_LAST) begin
				com_step = STEP_FIRST;
				com_wrap = 1'b1;
			end else begin
				com_step = step_q + 3'd1;
			end
			com_rising = com_step[0];
		end else begin
			if (step_q <= STEP_FIRST) begin
				com_step = STEP_LAST;
				com_wrap = 1'b1;
			end else begin
				com_step = step_q - 3'd1;
			end
			com_rising = ~com_step[0];
		end
	end

	always_comb begin
		plaus_on   = (avg_q > PLAUSIBLE_MIN);
		early      = q_word.low_early && (crossings_q < EARLY_CROSSES);
		too_soon   = (q_word.elapsed_time < {1'b0, smoothed_q[15:1]});
		stuck_inc  = (stuck_q == STUCK_MAX) ? STUCK_MAX : stuck_q + 8'd1;
		// a sample equal to the expected-edge flag fails the filter
		filter_ok  = rising_q ? ~q_word.has_one : ~q_word.has_zero;
		smooth_acc = {2'd0, smoothed_q} + {1'd0, smoothed_q, 1'b0}
			+ {2'd0, q_word.elapsed_time};
		smooth_new = smooth_acc[17:2];
		eighth     = smooth_new[15:3];
		adv        = (cfg.advance_steps[1] ? {1'b0, eighth, 1'b0} : 15'd0)
			+ (cfg.advance_steps[0] ? {2'd0, eighth} : 15'd0);
		half_diff  = smooth_new[15:1] - adv;
		div_prod   = sum_q[18:1] * RECIP_THREE;
		cross_inc  = (crossings_q < CROSS_MAX) ? crossings_q + 14'd1 : crossings_q;
	end

	always_comb begin
		sum_n       = sum_q;
		smoothed_n  = smoothed_q;
		step_n      = step_q;
		rising_n    = rising_q;
		crossings_n = crossings_q;
		avg_n       = avg_q;
		stuck_n     = stuck_q;
		running_n   = running_q;
		wrap_n      = wrap_q;
		hist_we     = 1'b0;
		action_n    = ACT_IGNORED;
		wait_n      = '0;
		drive_n     = 1'b0;
		unique case (q_word.command)
			CMD_ZERO_CROSS: begin
				if (plaus_on && (early || too_soon)) begin
					action_n = ACT_IGNORED;
				end else if (plaus_on && (stuck_inc > STUCK_LIMIT)) begin
					stuck_n     = stuck_inc;
					crossings_n = '0;
					action_n    = ACT_STUCK;
				end else begin
					if (plaus_on) begin
						stuck_n = stuck_inc;
					end
					if (filter_ok) begin
						smoothed_n = smooth_new;
						wait_n     = {1'b0, q_word.quick_accel ? (half_diff >> 1) : half_diff};
						action_n   = ACT_SCHEDULED;
					end
				end
			end
			CMD_COMMUTATE: begin
				hist_we     = 1'b1;
				sum_n       = com_sum;
				step_n      = com_step;
				rising_n    = com_rising;
				wrap_n      = wrap_q | com_wrap;
				crossings_n = cross_inc;
				action_n    = ACT_COMMUTATED;
				drive_n     = ~q_word.brake_hold;
			end
			CMD_TICK: begin
				avg_n   = div_prod[34:19];
				stuck_n = '0;
				if (crossings_q > DESYNC_CLEAR) begin
					wrap_n = 1'b0;
				end
			end
			CMD_START: begin
				if (!running_q) begin
					hist_we    = 1'b1;
					sum_n      = com_sum;
					step_n     = com_step;
					rising_n   = com_rising;
					wrap_n     = wrap_q | com_wrap;
					smoothed_n = START_INTERVAL;
					running_n  = 1'b1;
					action_n   = ACT_COMMUTATED;
					drive_n    = ~q_word.brake_hold;
				end
			end
			default: begin
				action_n = ACT_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			sum_q       <= '0;
			smoothed_q  <= RESET_INTERVAL;
			step_q      <= STEP_FIRST;
			rising_q    <= 1'b1;
			crossings_q <= '0;
			avg_q       <= '0;
			stuck_q     <= '0;
			running_q   <= 1'b0;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (hist_we) begin
					hist_q[com_idx] <= smoothed_q;
				end
				sum_q       <= sum_n;
				smoothed_q  <= smoothed_n;
				step_q      <= step_n;
				rising_q    <= rising_n;
				crossings_q <= crossings_n;
				avg_q       <= avg_n;
				stuck_q     <= stuck_n;
				running_q   <= running_n;
				wrap_q      <= wrap_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			action_q <= action_n;
			wait_q   <= wait_n;
			drive_q  <= drive_n;
		end
	end

	// state fields of the result track the registered state, which only moves on a pop
	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign wait_time    = wait_q;
	assign phase_step   = step_q;
	assign edge_rising  = rising_q;
	assign drive_update = drive_q;
	assign period_sum   = sum_q[18:1];
	assign desync_mark  = wrap_q;
	assign cross_count  = crossings_q;

endmodule

>>> rtl/bldc_sensorless_commutation_timer.sv
// Accepted words pass through the queue, then the result register.
// Throughput: one word per cycle while out_stall is low, one command per pop.
// A two-entry queue between front classifier and back end takes words while a
// result waits; the result register reloads in the cycle its word is taken.
// Reset (arst_n low, asynchronous): queue and result register empty, motor state
// at its power-up values, advance_steps 2, direction_forward 1.
module bldc_sensorless_commutation_timer #(
	parameter int QUEUE_DEPTH = bsct_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] elapsed_time,
	input  logic [23:0] comparator_history,
	input  logic [4:0]  filter_samples,
	input  logic [11:0] duty_level,
	input  logic        quick_accel,
	input  logic        brake_hold,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [15:0] wait_time,
	output logic [2:0]  phase_step,
	output logic        edge_rising,
	output logic        drive_update,
	output logic [17:0] period_sum,
	output logic        desync_mark,
	output logic [13:0] cross_count
);
	import bsct_pkg::*;

	cfg_t        cfg_q;
	logic        queue_full;
	logic        push;
	queue_word_t push_word;
	logic        pop;
	logic        pop_valid;
	queue_word_t pop_word;

	// config registers; to be written only while idle, which is left to the user
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.advance_steps     <= 2'd2;
			cfg_q.direction_forward <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADVANCE:   cfg_q.advance_steps     <= cfg_data;
				CFG_DIRECTION: cfg_q.direction_forward <= cfg_data[0];
				default:       cfg_q                   <= cfg_q;
			endcase
		end
	end

	// front: decode command, fold comparator filter and early-cross test
	bsct_front u_front (
		.in_valid           (in_valid),
		.command            (command),
		.elapsed_time       (elapsed_time),
		.comparator_history (comparator_history),
		.filter_samples     (filter_samples),
		.duty_level         (duty_level),
		.quick_accel        (quick_accel),
		.brake_hold         (brake_hold),
		.queue_full         (queue_full),
		.in_stall           (in_stall),
		.push               (push),
		.push_word          (push_word)
	);

	// short queue decoupling front from back
	bsct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_word  (pop_word),
		.full      (queue_full)
	);

	// back: motor state update and result register
	bsct_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (pop_valid),
		.q_word       (pop_word),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.wait_time    (wait_time),
		.phase_step   (phase_step),
		.edge_rising  (edge_rising),
		.drive_update (drive_update),
		.period_sum   (period_sum),
		.desync_mark  (desync_mark),
		.cross_count  (cross_count)
	);

endmodule

>>> dv/tb_bldc_sensorless_commutation_timer.sv
module tb_bldc_sensorless_commutation_timer;
	import bsct_pkg::*;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 11;
	localparam int TIMEOUT_CYCLES  = 600000;
	// leave margin for a result to pass the queue and the result register
	localparam int SETTLE_CYCLES   = 6;
	localparam int HOLD_OFF_CYCLES = 80;

	// motor-control thresholds, kept local so a wrong package constant shows up
	localparam int MIN_PLAUSIBLE      = 125;
	localparam int DUTY_LOW_LIMIT     = 600;
	localparam int EARLY_LIMIT        = 500;
	localparam int STUCK_ABORT_LIMIT  = 100;
	localparam int CROSS_SATURATE     = 10000;
	localparam int START_SEED         = 10000;
	localparam int POWER_UP_SMOOTH    = 12500;
	localparam int SAMPLE_WINDOW      = 24;
	localparam int DESYNC_CLEAR_COUNT = 10;

	// one input word, field order matches the port list
	typedef struct packed {
		cmd_t        command;
		logic [15:0] elapsed_time;
		logic [23:0] comparator_history;
		logic [4:0]  filter_samples;
		logic [11:0] duty_level;
		logic        quick_accel;
		logic        brake_hold;
	} word_t;

	// one result word
	typedef struct packed {
		action_t     action;
		logic [15:0] wait_time;
		logic [2:0]  phase_step;
		logic        edge_rising;
		logic        drive_update;
		logic [17:0] period_sum;
		logic        desync_mark;
		logic [13:0] cross_count;
	} result_t;

	// Tracks the motor timing state in parallel with the block and holds the
	// result words still owed by it.
	class commutation_scoreboard;
		bit [1:0]  adv;
		bit        fwd;
		bit [15:0] hist [6];
		bit [15:0] smooth;
		bit [2:0]  step_idx;
		bit        rising;
		bit [13:0] crossings;
		bit [15:0] avg_interval;
		bit [7:0]  stuck;
		bit        running;
		bit        wrap;
		bit [17:0] eperiod;

		result_t pending_timing [$];
		int      errors;
		int      checked;
		int      tally [4];

		function new();
			adv = 2'd2;
			fwd = 1'b1;
			foreach (hist[i])
				hist[i] = '0;
			smooth = 16'(POWER_UP_SMOOTH);
			step_idx = 3'd1;
			rising = 1'b1;
			crossings = '0;
			avg_interval = '0;
			stuck = '0;
			running = 1'b0;
			wrap = 1'b0;
			eperiod = '0;
			errors = 0;
			checked = 0;
			foreach (tally[i])
				tally[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [1:0] data);
			if (idx == CFG_ADVANCE)
				adv = data;
			else
				fwd = data[0];
		endfunction

		// store interval, rebuild period, move one step
		function void advance_phase();
			int unsigned total;
			total = 0;
			hist[step_idx - 3'd1] = smooth;
			foreach (hist[i])
				total += hist[i];
			eperiod = 18'(total >> 1);
			if (fwd) begin
				if (step_idx == 3'd6) begin
					step_idx = 3'd1;
					wrap = 1'b1;
				end else begin
					step_idx++;
				end
				rising = step_idx[0];
			end else begin
				if (step_idx <= 3'd1) begin
					step_idx = 3'd6;
					wrap = 1'b1;
				end else begin
					step_idx--;
				end
				rising = ~step_idx[0];
			end
		endfunction

		function void note_word(word_t w);
			result_t     r;
			bit          go;
			int unsigned n, i, s, adv_amt;
			r = '0;
			r.action = ACT_IGNORED;
			case (w.command)
				CMD_ZERO_CROSS: begin
					go = 1'b1;
					if (avg_interval > MIN_PLAUSIBLE) begin
						if (w.elapsed_time < MIN_PLAUSIBLE && w.duty_level < DUTY_LOW_LIMIT &&
								crossings < EARLY_LIMIT) begin
							go = 1'b0;
						end else if (w.elapsed_time < (smooth >> 1)) begin
							go = 1'b0;
						end else begin
							if (stuck != 8'hFF)
								stuck++;
							if (stuck > STUCK_ABORT_LIMIT) begin
								crossings = '0;
								r.action = ACT_STUCK;
								go = 1'b0;
							end
						end
					end
					if (go) begin
						n = (w.filter_samples > SAMPLE_WINDOW) ? SAMPLE_WINDOW : w.filter_samples;
						for (i = 0; i < n; i++)
							if (w.comparator_history[i] == rising)
								go = 1'b0;
					end
					if (go) begin
						s = (3 * smooth + w.elapsed_time) >> 2;
						smooth = s[15:0];
						adv_amt = (smooth >> 3) * adv;
						s = ((smooth >> 1) - adv_amt) >> w.quick_accel;
						r.wait_time = s[15:0];
						r.action = ACT_SCHEDULED;
					end
				end
				CMD_COMMUTATE: begin
					advance_phase();
					if (crossings < CROSS_SATURATE)
						crossings++;
					r.action = ACT_COMMUTATED;
					r.drive_update = ~w.brake_hold;
				end
				CMD_TICK: begin
					avg_interval = 16'(eperiod / 3);
					stuck = '0;
					if (crossings > DESYNC_CLEAR_COUNT)
						wrap = 1'b0;
				end
				CMD_START: begin
					if (!running) begin
						advance_phase();
						smooth = 16'(START_SEED);
						running = 1'b1;
						r.action = ACT_COMMUTATED;
						r.drive_update = ~w.brake_hold;
					end
				end
			endcase
			r.phase_step = step_idx;
			r.edge_rising = rising;
			r.period_sum = eperiod;
			r.desync_mark = wrap;
			r.cross_count = crossings;
			pending_timing.push_back(r);
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_timing.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing pending: expected none, actual action %0d",
					$time, got.action);
				return;
			end
			want = pending_timing.pop_front();
			checked++;
			tally[want.action]++;
			cmp("action", want.action, got.action);
			cmp("wait_time", want.wait_time, got.wait_time);
			cmp("phase_step", want.phase_step, got.phase_step);
			cmp("edge_rising", want.edge_rising, got.edge_rising);
			cmp("drive_update", want.drive_update, got.drive_update);
			cmp("period_sum", want.period_sum, got.period_sum);
			cmp("desync_mark", want.desync_mark, got.desync_mark);
			cmp("cross_count", want.cross_count, got.cross_count);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [1:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [15:0] elapsed_time;
	logic [23:0] comparator_history;
	logic [4:0]  filter_samples;
	logic [11:0] duty_level;
	logic        quick_accel;
	logic        brake_hold;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  action;
	logic [15:0] wait_time;
	logic [2:0]  phase_step;
	logic        edge_rising;
	logic        drive_update;
	logic [17:0] period_sum;
	logic        desync_mark;
	logic [13:0] cross_count;

	commutation_scoreboard timing_sb;
	bit hold_off_req  = 1'b0;
	bit hold_off_done = 1'b0;
	int n_settings    = 0;

	bldc_sensorless_commutation_timer u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.command            (command),
		.elapsed_time       (elapsed_time),
		.comparator_history (comparator_history),
		.filter_samples     (filter_samples),
		.duty_level         (duty_level),
		.quick_accel        (quick_accel),
		.brake_hold         (brake_hold),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.action             (action),
		.wait_time          (wait_time),
		.phase_step         (phase_step),
		.edge_rising        (edge_rising),
		.drive_update       (drive_update),
		.period_sum         (period_sum),
		.desync_mark        (desync_mark),
		.cross_count        (cross_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case a word is lost or the block locks up.
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("status: fail");
		$finish;
	end

	// Monitor: all sampling at the rising edge, before the block's own updates land.
	// Register writes, accepted inputs and accepted results all go to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				timing_sb.write_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				timing_sb.check_result({action, wait_time, phase_step, edge_rising,
					drive_update, period_sum, desync_mark, cross_count});
			if (in_valid && !in_stall)
				timing_sb.note_word({command, elapsed_time, comparator_history,
					filter_samples, duty_level, quick_accel, brake_hold});
		end
	end

	// Output side: segments of random length, each with its own stall pattern
	// (never, light, heavy, alternating). One long hold-off on request so the
	// internal queue fills and in_stall has to rise.
	initial begin
		int seg_len;
		int mode;
		int k;
		out_stall <= 1'b0;
		forever begin
			seg_len = $urandom_range(20, 120);
			mode = $urandom_range(0, 3);
			for (k = 0; k < seg_len; k++) begin
				@(posedge clk);
				if (hold_off_req && !hold_off_done) begin
					out_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_off_done = 1'b1;
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Offer one word and hold it until the block takes it.
	task automatic send_word(input word_t w);
		in_valid <= 1'b1;
		command <= w.command;
		elapsed_time <= w.elapsed_time;
		comparator_history <= w.comparator_history;
		filter_samples <= w.filter_samples;
		duty_level <= w.duty_level;
		quick_accel <= w.quick_accel;
		brake_hold <= w.brake_hold;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic word_t make_word(cmd_t cmd, logic [15:0] elapsed, logic [23:0] comp,
			logic [4:0] nfilt, logic [11:0] duty, logic fast, logic brake);
		word_t w;
		w.command = cmd;
		w.elapsed_time = elapsed;
		w.comparator_history = comp;
		w.filter_samples = nfilt;
		w.duty_level = duty;
		w.quick_accel = fast;
		w.brake_hold = brake;
		return w;
	endfunction

	// Random word from a command mix. Most zero crosses are well formed: elapsed
	// near the running speed and a clean comparator level in the checked window
	// (either polarity, so about half match the expected edge). The rest are
	// short intervals, a flipped sample, or plain noise.
	function automatic word_t gen_word(int zc_w, int com_w, int tick_w, int start_w,
			int unsigned base);
		word_t       w;
		int unsigned pick;
		int unsigned cat;
		logic [23:0] mask;
		logic [23:0] lvl;
		w = make_word(CMD_ZERO_CROSS, 16'($urandom), 24'($urandom),
			5'($urandom_range(0, 31)), 12'($urandom), 1'($urandom), 1'($urandom));
		pick = $urandom_range(0, zc_w + com_w + tick_w + start_w - 1);
		if (pick < zc_w)
			w.command = CMD_ZERO_CROSS;
		else if (pick < zc_w + com_w)
			w.command = CMD_COMMUTATE;
		else if (pick < zc_w + com_w + tick_w)
			w.command = CMD_TICK;
		else
			w.command = CMD_START;
		if (w.command == CMD_ZERO_CROSS) begin
			cat = $urandom_range(0, 99);
			if (cat >= 8) begin
				if (cat < 18) begin
					w.elapsed_time = 16'($urandom_range(0, 130));
					w.duty_level = 12'($urandom_range(0, 700));
				end else begin
					w.elapsed_time = 16'(base + $urandom_range(0, base / 2));
				end
				mask = (w.filter_samples >= SAMPLE_WINDOW) ? 24'hFFFFFF :
					((24'd1 << w.filter_samples) - 24'd1);
				lvl = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
				w.comparator_history = (lvl & mask) | (w.comparator_history & ~mask);
				if ($urandom_range(0, 15) == 0)
					w.comparator_history ^= 24'd1 << $urandom_range(0, 23);
			end
		end
		return w;
	endfunction

	// Bursts of random length; gaps between them, sometimes none.
	task automatic run_phase(int n_words, int zc_w, int com_w, int tick_w, int start_w);
		int          remaining;
		int          burst;
		int          gap;
		int unsigned base;
		remaining = n_words;
		while (remaining > 0) begin
			burst = $urandom_range(1, 24);
			base = ($urandom_range(0, 19) == 0) ? $urandom_range(40000, 43000) :
				$urandom_range(200, 20000);
			while (burst > 0 && remaining > 0) begin
				send_word(gen_word(zc_w, com_w, tick_w, start_w, base));
				burst--;
				remaining--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0 && remaining > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Wait until every owed result is back, then let the block settle.
	task automatic drain();
		@(posedge clk);
		while (timing_sb.pending_timing.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers in back-to-back cycles; block must be idle.
	task automatic set_config(logic [1:0] adv, logic fwd);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ADVANCE;
		cfg_data <= adv;
		@(posedge clk);
		cfg_index <= CFG_DIRECTION;
		cfg_data <= {1'b0, fwd};
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		timing_sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ADVANCE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_ZERO_CROSS;
		elapsed_time <= '0;
		comparator_history <= '0;
		filter_samples <= '0;
		duty_level <= '0;
		quick_accel <= 1'b0;
		brake_hold <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, power-up registers (advance 2, forward).
		// zero cross before start: no plausibility yet, empty filter
		send_word(make_word(CMD_ZERO_CROSS, 16'd0, 24'h000000, 5'd0, 12'd0, 1'b0, 1'b0));
		// wrong comparator level over the full window
		send_word(make_word(CMD_ZERO_CROSS, 16'hFFFF, 24'hFFFFFF, 5'd24, 12'hFFF, 1'b1, 1'b1));
		send_word(make_word(CMD_TICK, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		send_word(make_word(CMD_START, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		// start while running does nothing
		send_word(make_word(CMD_START, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b1));
		send_word(make_word(CMD_COMMUTATE, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b1));
		// filter longer than the history: all 24 samples checked
		send_word(make_word(CMD_ZERO_CROSS, 16'hFFFF, 24'h000000, 5'd31, 12'hFFF, 1'b1, 1'b0));
		send_word(make_word(CMD_ZERO_CROSS, 16'd5000, 24'h000001, 5'd1, 12'd0, 1'b0, 1'b0));
		send_word(make_word(CMD_COMMUTATE, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		// falling edge expected: checked samples must be ones
		send_word(make_word(CMD_ZERO_CROSS, 16'd20000, 24'hFFFFFF, 5'd5, 12'd0, 1'b0, 1'b0));
		send_word(make_word(CMD_ZERO_CROSS, 16'd20000, 24'hFFFFFE, 5'd24, 12'd0, 1'b0, 1'b0));
		// around the cycle, sets the desync mark
		repeat (5)
			send_word(make_word(CMD_COMMUTATE, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		// too few crossings: desync mark stays
		send_word(make_word(CMD_TICK, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		// plausibility now active: early crosses at low duty, then too short
		send_word(make_word(CMD_ZERO_CROSS, 16'd10, 24'h0, 5'd0, 12'd100, 1'b0, 1'b0));
		send_word(make_word(CMD_ZERO_CROSS, 16'd124, 24'h0, 5'd0, 12'd599, 1'b0, 1'b0));
		send_word(make_word(CMD_ZERO_CROSS, 16'd100, 24'h0, 5'd0, 12'hFFF, 1'b0, 1'b0));
		send_word(make_word(CMD_ZERO_CROSS, 16'hFFFF, 24'h0, 5'd0, 12'd600, 1'b0, 1'b0));
		repeat (4)
			send_word(make_word(CMD_COMMUTATE, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		// crossings above the clear count: desync mark cleared
		send_word(make_word(CMD_TICK, 16'd0, 24'h0, 5'd0, 12'd0, 1'b0, 1'b0));
		in_valid <= 1'b0;
		drain();

		// Random phases. Output hold-off lands during the first one.
		set_config(2'd0, 1'b1);
		hold_off_req = 1'b1;
		run_phase(95, 45, 40, 10, 5);
		drain();

		set_config(2'd3, 1'b0);
		run_phase(95, 45, 40, 10, 5);
		drain();

		// no ticks: stuck count climbs past the abort limit and saturates
		set_config(2'd1, 1'b1);
		run_phase(250, 96, 3, 0, 1);
		drain();

		// commutation-heavy stretch, backward stepping
		set_config(2'd2, 1'b0);
		run_phase(90, 0, 99, 1, 0);
		drain();

		// mixed traffic under a random register setting
		set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		run_phase(50, 45, 40, 10, 5);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("checked %0d results: %0d scheduled, %0d stuck aborts, %0d commutations, %0d ignored",
			timing_sb.checked, timing_sb.tally[ACT_SCHEDULED], timing_sb.tally[ACT_STUCK],
			timing_sb.tally[ACT_COMMUTATED], timing_sb.tally[ACT_IGNORED]);
		$display("%0d register settings, one long output hold-off, commutation-heavy stretch",
			n_settings);
		if (timing_sb.errors == 0 && timing_sb.pending_timing.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/bsct_pkg.sv
rtl/bsct_front.sv
rtl/bsct_queue.sv
rtl/bsct_back.sv
rtl/bldc_sensorless_commutation_timer.sv
dv/tb_bldc_sensorless_commutation_timer.sv
